@@ rtl/jmlp_pkg.sv @@
// shared types and constants for the message line parser
`default_nettype none
package jmlp_pkg;

    localparam int ID_BITS_DEF  = 31;
    localparam int MAX_ARGS_DEF = 256;

    typedef enum logic [4:0] {
        PH_BRACE, PH_KEY_OPEN, PH_KEY, PH_COLON, PH_ID_FIRST, PH_ID_MORE,
        PH_TYPE_OPEN, PH_TYPE_CHAR, PH_TYPE_ESC, PH_ARGS_OPEN, PH_ARG_OPEN,
        PH_ARG_CHAR, PH_ARG_ESC, PH_ARG_HEX, PH_ARG_AFTER, PH_AFTER_VALUE
    } phase_t;

    localparam logic [2:0] KIND_TYPE_CHAR = 3'd0;
    localparam logic [2:0] KIND_TYPE_END  = 3'd1;
    localparam logic [2:0] KIND_ARG_CHAR  = 3'd2;
    localparam logic [2:0] KIND_ARG_END   = 3'd3;
    localparam logic [2:0] KIND_OK        = 3'd4;
    localparam logic [2:0] KIND_ERROR     = 3'd5;

    localparam logic [2:0] ERR_SYNTAX   = 3'd0;
    localparam logic [2:0] ERR_KEY      = 3'd1;
    localparam logic [2:0] ERR_EARLY    = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW = 3'd3;
    localparam logic [2:0] ERR_ARGS     = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  char_value;
        logic [7:0]  arg_index;
        logic [30:0] message_id;
        logic        id_present;
        logic [2:0]  error_code;
    } result_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        begin
            v = 4'd0;
            if (c >= 8'h30 && c <= 8'h39)
                v = c[3:0];
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
                v = c[3:0] + 4'd9;
            hex_value = v;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/jmlp_front.sv @@
// front end: grammar state machine, classifies each byte into an optional result
`default_nettype none
module jmlp_front #(
    parameter int ID_BITS  = jmlp_pkg::ID_BITS_DEF,
    parameter int MAX_ARGS = jmlp_pkg::MAX_ARGS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        char_in,
    input  wire logic              end_of_line,
    output jmlp_pkg::result_t      res,
    output logic                   res_valid
);
    localparam int CW = $clog2(MAX_ARGS + 1);
    localparam logic [ID_BITS-1:0] ID_LIMIT = {ID_BITS{1'b1}};

    jmlp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]         keypos_reg, keypos_next;
    logic [2:0]         cand_reg, cand_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic               seen_reg, seen_next;
    logic [7:0]         hex_reg, hex_next;
    logic [2:0]         hleft_reg, hleft_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               err_reg, err_next;

    logic               digit;
    logic [3:0]         dval;
    logic [ID_BITS+3:0] id_times;
    logic [ID_BITS+3:0] id_sum;
    logic               ovf;
    logic               e_v;
    logic [2:0]         e_code;
    logic               k_v;
    logic [2:0]         k_kind;
    logic [7:0]         k_val;
    logic [7:0]         k_idx;
    logic               restart;
    logic [7:0]         hacc;

    assign digit    = char_in >= 8'h30 && char_in <= 8'h39;
    assign dval     = char_in[3:0];
    assign id_times = ({4'd0, id_reg} << 3) + ({4'd0, id_reg} << 1);
    assign id_sum   = id_times + {{ID_BITS{1'b0}}, dval};
    assign ovf      = id_sum > {4'd0, ID_LIMIT};
    assign hacc     = {hex_reg[3:0], jmlp_pkg::hex_value(char_in)};

    always_comb
    begin
        phase_next = phase_reg;
        keypos_next = keypos_reg;
        cand_next = cand_reg;
        id_next = id_reg;
        seen_next = seen_reg;
        hex_next = hex_reg;
        hleft_next = hleft_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        e_v = 1'b0;
        e_code = jmlp_pkg::ERR_SYNTAX;
        k_v = 1'b0;
        k_kind = jmlp_pkg::KIND_TYPE_CHAR;
        k_val = 8'd0;
        k_idx = 8'd0;
        restart = 1'b0;
        res = '0;
        res_valid = 1'b0;
        if (err_reg)
        begin
            restart = end_of_line;
        end
        else if (char_in == 8'd0)
        begin
            e_v = 1'b1;
            e_code = jmlp_pkg::ERR_EARLY;
        end
        else
        begin
            unique case (phase_reg)
                jmlp_pkg::PH_BRACE:
                    if (char_in == "{") phase_next = jmlp_pkg::PH_KEY_OPEN;
                    else e_v = 1'b1;
                jmlp_pkg::PH_KEY_OPEN:
                    if (char_in == "\"")
                    begin
                        phase_next = jmlp_pkg::PH_KEY;
                        keypos_next = 3'd0;
                        cand_next = 3'b111;
                    end
                    else e_v = 1'b1;
                jmlp_pkg::PH_KEY:
                    if (char_in == "\"")
                    begin
                        cand_next[0] = cand_reg[0] && keypos_reg == 3'd2;
                        cand_next[1] = cand_reg[1] && keypos_reg == 3'd4;
                        cand_next[2] = cand_reg[2] && keypos_reg == 3'd4;
                        phase_next = jmlp_pkg::PH_COLON;
                    end
                    else
                    begin
                        case (keypos_reg)
                            3'd0: cand_next = cand_reg & {char_in == "a",
                                char_in == "t", char_in == "i"};
                            3'd1: cand_next = cand_reg & {char_in == "r",
                                char_in == "y", char_in == "d"};
                            3'd2: cand_next = cand_reg & {char_in == "g",
                                char_in == "p", 1'b0};
                            3'd3: cand_next = cand_reg & {char_in == "s",
                                char_in == "e", 1'b0};
                            default: cand_next = 3'b000;
                        endcase
                        if (keypos_reg != 3'd7) keypos_next = keypos_reg + 3'd1;
                    end
                jmlp_pkg::PH_COLON:
                    if (char_in != ":") e_v = 1'b1;
                    else if (cand_reg[0])
                    begin
                        id_next = '0;
                        phase_next = jmlp_pkg::PH_ID_FIRST;
                    end
                    else if (cand_reg[1]) phase_next = jmlp_pkg::PH_TYPE_OPEN;
                    else if (cand_reg[2]) phase_next = jmlp_pkg::PH_ARGS_OPEN;
                    else
                    begin
                        e_v = 1'b1;
                        e_code = jmlp_pkg::ERR_KEY;
                    end
                jmlp_pkg::PH_ID_FIRST:
                    if (digit)
                    begin
                        phase_next = jmlp_pkg::PH_ID_MORE;
                        if (ovf)
                        begin
                            e_v = 1'b1;
                            e_code = jmlp_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            id_next = id_sum[ID_BITS-1:0];
                            seen_next = 1'b1;
                        end
                    end
                    else e_v = 1'b1;
                jmlp_pkg::PH_TYPE_OPEN:
                    if (char_in == "\"") phase_next = jmlp_pkg::PH_TYPE_CHAR;
                    else e_v = 1'b1;
                jmlp_pkg::PH_TYPE_CHAR:
                    if (char_in == "\\") phase_next = jmlp_pkg::PH_TYPE_ESC;
                    else if (char_in == "\"")
                    begin
                        k_v = 1'b1;
                        k_kind = jmlp_pkg::KIND_TYPE_END;
                        phase_next = jmlp_pkg::PH_AFTER_VALUE;
                    end
                    else
                    begin
                        k_v = 1'b1;
                        k_val = char_in;
                    end
                jmlp_pkg::PH_TYPE_ESC:
                begin
                    k_v = 1'b1;
                    k_val = char_in;
                    phase_next = jmlp_pkg::PH_TYPE_CHAR;
                end
                jmlp_pkg::PH_ARGS_OPEN:
                    if (char_in == "[")
                    begin
                        cnt_next = '0;
                        phase_next = jmlp_pkg::PH_ARG_OPEN;
                    end
                    else e_v = 1'b1;
                jmlp_pkg::PH_ARG_OPEN:
                    if (char_in == "]") phase_next = jmlp_pkg::PH_AFTER_VALUE;
                    else if (char_in == "\"")
                    begin
                        if (cnt_reg >= CW'(MAX_ARGS))
                        begin
                            e_v = 1'b1;
                            e_code = jmlp_pkg::ERR_ARGS;
                        end
                        else phase_next = jmlp_pkg::PH_ARG_CHAR;
                    end
                    else e_v = 1'b1;
                jmlp_pkg::PH_ARG_CHAR:
                begin
                    k_idx = 8'(cnt_reg);
                    if (char_in == "\\") phase_next = jmlp_pkg::PH_ARG_ESC;
                    else if (char_in == "\"")
                    begin
                        k_v = 1'b1;
                        k_kind = jmlp_pkg::KIND_ARG_END;
                        cnt_next = cnt_reg + CW'(1);
                        phase_next = jmlp_pkg::PH_ARG_AFTER;
                    end
                    else
                    begin
                        k_v = 1'b1;
                        k_kind = jmlp_pkg::KIND_ARG_CHAR;
                        k_val = char_in;
                    end
                end
                jmlp_pkg::PH_ARG_ESC:
                begin
                    k_idx = 8'(cnt_reg);
                    if (char_in == "u")
                    begin
                        hex_next = 8'd0;
                        hleft_next = 3'd4;
                        phase_next = jmlp_pkg::PH_ARG_HEX;
                    end
                    else
                    begin
                        k_v = 1'b1;
                        k_kind = jmlp_pkg::KIND_ARG_CHAR;
                        k_val = char_in;
                        phase_next = jmlp_pkg::PH_ARG_CHAR;
                    end
                end
                jmlp_pkg::PH_ARG_HEX:
                begin
                    k_idx = 8'(cnt_reg);
                    hex_next = hacc;
                    if (hleft_reg != 3'd0) hleft_next = hleft_reg - 3'd1;
                    if (hleft_reg <= 3'd1)
                    begin
                        k_v = 1'b1;
                        k_kind = jmlp_pkg::KIND_ARG_CHAR;
                        k_val = hacc;
                        phase_next = jmlp_pkg::PH_ARG_CHAR;
                    end
                end
                jmlp_pkg::PH_ARG_AFTER:
                    if (char_in == ",") phase_next = jmlp_pkg::PH_ARG_OPEN;
                    else if (char_in == "]") phase_next = jmlp_pkg::PH_AFTER_VALUE;
                    else e_v = 1'b1;
                jmlp_pkg::PH_ID_MORE, jmlp_pkg::PH_AFTER_VALUE:
                    if (phase_reg == jmlp_pkg::PH_ID_MORE && digit)
                    begin
                        if (ovf)
                        begin
                            e_v = 1'b1;
                            e_code = jmlp_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            id_next = id_sum[ID_BITS-1:0];
                            seen_next = 1'b1;
                        end
                    end
                    else if (char_in == ",") phase_next = jmlp_pkg::PH_KEY_OPEN;
                    else if (char_in == "}" && end_of_line)
                    begin
                        k_v = 1'b1;
                        k_kind = jmlp_pkg::KIND_OK;
                    end
                    else e_v = 1'b1;
                default: e_v = 1'b1;
            endcase

            if (e_v)
            begin
                res_valid = 1'b1;
                res.kind = jmlp_pkg::KIND_ERROR;
                res.error_code = e_code;
                err_next = 1'b1;
                restart = end_of_line;
            end
            else if (k_v && k_kind == jmlp_pkg::KIND_OK)
            begin
                res_valid = 1'b1;
                res.kind = jmlp_pkg::KIND_OK;
                res.message_id = seen_reg ? 31'(id_reg) : 31'd0;
                res.id_present = seen_reg;
                restart = 1'b1;
            end
            else if (end_of_line)
            begin
                res_valid = 1'b1;
                res.kind = jmlp_pkg::KIND_ERROR;
                res.error_code = jmlp_pkg::ERR_EARLY;
                restart = 1'b1;
            end
            else if (k_v)
            begin
                res_valid = 1'b1;
                res.kind = k_kind;
                res.char_value = k_val;
                res.arg_index = (k_kind == jmlp_pkg::KIND_TYPE_CHAR ||
                    k_kind == jmlp_pkg::KIND_TYPE_END) ? 8'd0 : k_idx;
            end
        end
        if (!err_reg && char_in == 8'd0)
        begin
            res_valid = 1'b1;
            res = '0;
            res.kind = jmlp_pkg::KIND_ERROR;
            res.error_code = jmlp_pkg::ERR_EARLY;
            restart = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jmlp_pkg::PH_BRACE;
            keypos_reg <= '0;
            cand_reg <= 3'b111;
            id_reg <= '0;
            seen_reg <= 1'b0;
            hex_reg <= '0;
            hleft_reg <= '0;
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (step)
        begin
            if (restart)
            begin
                phase_reg <= jmlp_pkg::PH_BRACE;
                keypos_reg <= '0;
                cand_reg <= 3'b111;
                id_reg <= '0;
                seen_reg <= 1'b0;
                hex_reg <= '0;
                hleft_reg <= '0;
                cnt_reg <= '0;
                err_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                keypos_reg <= keypos_next;
                cand_reg <= cand_next;
                id_reg <= id_next;
                seen_reg <= seen_next;
                hex_reg <= hex_next;
                hleft_reg <= hleft_next;
                cnt_reg <= cnt_next;
                err_reg <= err_next;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/jmlp_queue.sv @@
// short result queue between front end and output side
`default_nettype none
module jmlp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr,
    input  jmlp_pkg::result_t      wr_data,
    output logic                   full,
    input  wire logic              rd,
    output jmlp_pkg::result_t      rd_data,
    output logic                   empty
);
    jmlp_pkg::result_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr && !full) wp_reg <= ~wp_reg;
            if (rd && !empty) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr && !full) - 2'(rd && !empty);
        end
    end
endmodule
`default_nettype wire

@@ rtl/jmlp_back.sv @@
// back end: output register stage presenting results as a queue
`default_nettype none
module jmlp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  jmlp_pkg::result_t      q_data,
    input  wire logic              q_empty,
    output logic                   q_rd,
    input  wire logic              pop,
    output logic                   empty,
    output jmlp_pkg::result_t      out_data
);
    logic              valid_reg;
    jmlp_pkg::result_t data_reg;

    assign empty    = !valid_reg;
    assign out_data = data_reg;
    assign q_rd     = !q_empty && (!valid_reg || pop);

    always_ff @(posedge clk)
    begin
        if (q_rd) data_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (q_rd) valid_reg <= 1'b1;
        else if (pop) valid_reg <= 1'b0;
    end
endmodule
`default_nettype wire

@@ rtl/json_message_line_parser.sv @@
// top level of the message line parser
// a result passes through the result queue and then the output register before it reaches the output ports
// throughput: one byte per cycle while full is low, set by the grammar state machine
// full rises only when the two-entry result queue is full and output is stalled
// reset clears the parser state, the queue and the output stage
`default_nettype none
module json_message_line_parser #(
    parameter int ID_BITS  = jmlp_pkg::ID_BITS_DEF,
    parameter int MAX_ARGS = jmlp_pkg::MAX_ARGS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  char_in,
    input  wire logic        end_of_line,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       kind,
    output logic [7:0]       char_value,
    output logic [7:0]       arg_index,
    output logic [30:0]      message_id,
    output logic             id_present,
    output logic [2:0]       error_code
);
    jmlp_pkg::result_t f_res, q_data, o_data;
    logic f_valid, q_full, q_empty, q_rd, step;

    assign full = q_full;
    assign step = push && !q_full;

    jmlp_front #(.ID_BITS(ID_BITS), .MAX_ARGS(MAX_ARGS)) u_front (
        .clk(clk), .rst_n(rst_n), .step(step), .char_in(char_in),
        .end_of_line(end_of_line), .res(f_res), .res_valid(f_valid)
    );

    jmlp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(step && f_valid), .wr_data(f_res),
        .full(q_full), .rd(q_rd), .rd_data(q_data), .empty(q_empty)
    );

    jmlp_back u_back (
        .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_empty(q_empty),
        .q_rd(q_rd), .pop(pop), .empty(empty), .out_data(o_data)
    );

    assign kind       = o_data.kind;
    assign char_value = o_data.char_value;
    assign arg_index  = o_data.arg_index;
    assign message_id = o_data.message_id;
    assign id_present = o_data.id_present;
    assign error_code = o_data.error_code;
endmodule
`default_nettype wire
